// File: rtl/multi_timer_service_defines.svh
// assertion macros for the timer service rtl
`ifndef MULTI_TIMER_SERVICE_DEFINES_SVH
`define MULTI_TIMER_SERVICE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define MTS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define MTS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/mts_pkg.sv
package mts_pkg;

	// channel table size and derived index width
	localparam int NUM_TIMERS = 16;
	localparam int CH_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
	localparam logic [CH_W-1:0] LAST_IDX = CH_W'(NUM_TIMERS - 1);

	// field widths
	localparam int FUNC_W = 3;
	localparam int HANDLE_W = 4;
	localparam int WORD_W = 32;

	// longest interval accepted by create
	localparam logic [WORD_W-1:0] MAX_INTERVAL = 32'd2147483646;

	// command queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	// function codes on the command word
	localparam logic [FUNC_W-1:0] FUNC_TICK = 3'd0;
	localparam logic [FUNC_W-1:0] FUNC_CREATE = 3'd1;
	localparam logic [FUNC_W-1:0] FUNC_STOP = 3'd2;
	localparam logic [FUNC_W-1:0] FUNC_RESTART = 3'd3;
	localparam logic [FUNC_W-1:0] FUNC_DELETE = 3'd4;
	localparam logic [FUNC_W-1:0] FUNC_QUERY = 3'd5;

	// result kinds
	localparam logic KIND_RESP = 1'b0;
	localparam logic KIND_EVENT = 1'b1;

	// status codes
	localparam logic [1:0] STAT_OK = 2'd0;
	localparam logic [1:0] STAT_BAD_HANDLE = 2'd1;
	localparam logic [1:0] STAT_NO_FREE = 2'd2;
	localparam logic [1:0] STAT_TOO_LONG = 2'd3;

	typedef enum logic [2:0] {
		OP_TICK,
		OP_CREATE,
		OP_STOP,
		OP_RESTART,
		OP_DELETE,
		OP_QUERY
	} op_t;

	// classified command as held in the queue
	typedef struct packed {
		op_t op;
		logic [HANDLE_W-1:0] handle;
		logic handle_ok;
		logic too_long;
		logic [WORD_W-1:0] interval_ms;
		logic [WORD_W-1:0] user_tag;
		logic start_active;
		logic auto_reload;
		logic trigger_callback;
	} qitem_t;

	// one result word
	typedef struct packed {
		logic kind;
		logic [1:0] status;
		logic [HANDLE_W-1:0] channel;
		logic [WORD_W-1:0] tag_out;
		logic is_active;
		logic callback;
		logic last_item;
	} res_t;

	function automatic logic [CH_W-1:0] to_idx(input logic [HANDLE_W-1:0] h);
		return CH_W'(h);
	endfunction

	function automatic logic [HANDLE_W-1:0] to_chan(input logic [CH_W-1:0] i);
		return HANDLE_W'(i);
	endfunction

endpackage

// File: rtl/mts_if.sv
// command channel
interface mts_cmd_if;
	logic valid;
	logic ready;
	logic [mts_pkg::FUNC_W-1:0] func;
	logic [mts_pkg::HANDLE_W-1:0] handle;
	logic [mts_pkg::WORD_W-1:0] interval_ms;
	logic [mts_pkg::WORD_W-1:0] user_tag;
	logic start_active;
	logic auto_reload;
	logic trigger_callback;

	modport source (
		output valid, func, handle, interval_ms, user_tag, start_active, auto_reload,
			trigger_callback,
		input ready
	);
	modport sink (
		input valid, func, handle, interval_ms, user_tag, start_active, auto_reload,
			trigger_callback,
		output ready
	);
endinterface

// result channel
interface mts_rsp_if;
	logic valid;
	logic ready;
	logic kind;
	logic [1:0] status;
	logic [mts_pkg::HANDLE_W-1:0] channel;
	logic [mts_pkg::WORD_W-1:0] tag_out;
	logic is_active;
	logic callback;
	logic last_item;

	modport source (
		output valid, kind, status, channel, tag_out, is_active, callback, last_item,
		input ready
	);
	modport sink (
		input valid, kind, status, channel, tag_out, is_active, callback, last_item,
		output ready
	);
endinterface

// File: rtl/mts_front.sv
module mts_front (
	input logic clk,
	input logic arst_n,
	mts_cmd_if.sink cmd,
	output logic q_valid,
	output mts_pkg::qitem_t q_item,
	input logic q_ready
);
	import mts_pkg::*;

	qitem_t mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	qitem_t item;
	logic keep;
	logic push;
	logic pop;

	// classify the incoming word; unknown codes are taken and dropped
	always_comb begin
		item = '0;
		keep = 1'b1;
		item.handle = cmd.handle;
		item.handle_ok = (32'(cmd.handle) < NUM_TIMERS);
		item.too_long = (cmd.interval_ms > MAX_INTERVAL);
		item.interval_ms = cmd.interval_ms;
		item.user_tag = cmd.user_tag;
		item.start_active = cmd.start_active;
		item.auto_reload = cmd.auto_reload;
		item.trigger_callback = cmd.trigger_callback;
		unique case (cmd.func)
			FUNC_TICK: item.op = OP_TICK;
			FUNC_CREATE: item.op = OP_CREATE;
			FUNC_STOP: item.op = OP_STOP;
			FUNC_RESTART: item.op = OP_RESTART;
			FUNC_DELETE: item.op = OP_DELETE;
			FUNC_QUERY: item.op = OP_QUERY;
			default: begin
				item.op = OP_TICK;
				keep = 1'b0;
			end
		endcase
	end

	assign cmd.ready = (count_q != QCNT_W'(QUEUE_DEPTH));
	assign push = cmd.valid && cmd.ready && keep;
	assign q_valid = (count_q != '0);
	assign q_item = mem_q[rd_ptr_q];
	assign pop = q_valid && q_ready;

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= item;
		end
	end

	// queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: rtl/mts_ram.sv
module mts_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input logic clk,
	input logic we,
	input logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: rtl/mts_back.sv
`include "multi_timer_service_defines.svh"

module mts_back (
	input logic clk,
	input logic arst_n,
	input logic q_valid,
	input mts_pkg::qitem_t q_item,
	output logic q_ready,
	mts_rsp_if.source rsp
);
	import mts_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_EXEC = 3'd1;
	localparam logic [2:0] ST_TICK_EV = 3'd2;
	localparam logic [2:0] ST_TICK_END = 3'd3;

	logic [2:0] state_q, state_d;
	logic [CH_W-1:0] idx_q, idx_d;
	qitem_t cur_q, cur_d;
	logic pend_v_q, pend_v_d;
	res_t pend_q, pend_d;
	logic [NUM_TIMERS-1:0] allocated_q, alloc_d;
	logic [NUM_TIMERS-1:0] running_q, run_d;
	logic out_v_q;
	res_t out_q;
	logic out_free;
	logic push;
	res_t push_res;

	// channel memories
	logic [CH_W-1:0] raddr;
	logic cfg_we;
	logic rem_we;
	logic [CH_W-1:0] rem_wa;
	logic [WORD_W-1:0] rem_wd;
	logic [WORD_W-1:0] rem_rd;
	logic [WORD_W-1:0] period_rd;
	logic [WORD_W-1:0] tag_rd;
	logic periodic_rd;

	// lowest free channel
	logic [CH_W-1:0] free_idx;
	logic free_any;
	logic [CH_W-1:0] c;
	logic good;
	logic live;
	logic expire;

	mts_ram #(.WIDTH(WORD_W), .DEPTH(NUM_TIMERS)) u_remaining (
		.clk(clk), .we(rem_we), .waddr(rem_wa), .wdata(rem_wd),
		.raddr(raddr), .rdata(rem_rd)
	);
	mts_ram #(.WIDTH(WORD_W), .DEPTH(NUM_TIMERS)) u_period (
		.clk(clk), .we(cfg_we), .waddr(free_idx), .wdata(cur_q.interval_ms),
		.raddr(raddr), .rdata(period_rd)
	);
	mts_ram #(.WIDTH(WORD_W), .DEPTH(NUM_TIMERS)) u_tag (
		.clk(clk), .we(cfg_we), .waddr(free_idx), .wdata(cur_q.user_tag),
		.raddr(raddr), .rdata(tag_rd)
	);
	mts_ram #(.WIDTH(1), .DEPTH(NUM_TIMERS)) u_periodic (
		.clk(clk), .we(cfg_we), .waddr(free_idx), .wdata(cur_q.auto_reload),
		.raddr(raddr), .rdata(periodic_rd)
	);

	// priority search for the lowest unallocated channel
	always_comb begin
		free_idx = '0;
		for (int i = NUM_TIMERS - 1; i >= 0; i--) begin
			if (!allocated_q[i]) begin
				free_idx = CH_W'(i);
			end
		end
		free_any = ~&allocated_q;
	end

	assign out_free = !out_v_q || rsp.ready;
	assign c = to_idx(cur_q.handle);
	assign good = cur_q.handle_ok && allocated_q[c];
	assign live = allocated_q[idx_q] && running_q[idx_q];
	assign expire = live && (rem_rd <= 32'd1);

	// command sequencer and tick scan
	always_comb begin
		state_d = state_q;
		idx_d = idx_q;
		cur_d = cur_q;
		pend_v_d = pend_v_q;
		pend_d = pend_q;
		alloc_d = allocated_q;
		run_d = running_q;
		q_ready = 1'b0;
		push = 1'b0;
		push_res = '0;
		cfg_we = 1'b0;
		rem_we = 1'b0;
		rem_wa = idx_q;
		rem_wd = rem_rd;
		raddr = idx_q;
		unique case (state_q)
			ST_IDLE: begin
				q_ready = 1'b1;
				raddr = (q_item.op == OP_TICK) ? '0 : to_idx(q_item.handle);
				if (q_valid) begin
					cur_d = q_item;
					if (q_item.op == OP_TICK) begin
						idx_d = '0;
						pend_v_d = 1'b0;
						state_d = ST_TICK_EV;
					end else begin
						state_d = ST_EXEC;
					end
				end
			end
			ST_EXEC: begin
				raddr = c;
				if (out_free) begin
					push = 1'b1;
					state_d = ST_IDLE;
					push_res.kind = KIND_RESP;
					push_res.last_item = 1'b1;
					if (cur_q.op == OP_CREATE) begin
						if (cur_q.too_long) begin
							push_res.status = STAT_TOO_LONG;
						end else if (!free_any) begin
							push_res.status = STAT_NO_FREE;
						end else begin
							cfg_we = 1'b1;
							rem_we = 1'b1;
							rem_wa = free_idx;
							rem_wd = cur_q.interval_ms;
							alloc_d[free_idx] = 1'b1;
							run_d[free_idx] = cur_q.start_active;
							push_res.status = STAT_OK;
							push_res.channel = to_chan(free_idx);
							push_res.tag_out = cur_q.user_tag;
							push_res.is_active = cur_q.start_active;
						end
					end else if (!good) begin
						push_res.status = STAT_BAD_HANDLE;
						push_res.channel = cur_q.handle;
					end else begin
						push_res.status = STAT_OK;
						push_res.channel = cur_q.handle;
						push_res.tag_out = tag_rd;
						unique case (cur_q.op)
							OP_STOP: begin
								run_d[c] = 1'b0;
								push_res.callback = running_q[c] && cur_q.trigger_callback;
							end
							OP_RESTART: begin
								rem_we = 1'b1;
								rem_wa = c;
								rem_wd = period_rd;
								run_d[c] = 1'b1;
								push_res.is_active = 1'b1;
								push_res.callback = cur_q.trigger_callback;
							end
							OP_DELETE: begin
								alloc_d[c] = 1'b0;
								run_d[c] = 1'b0;
							end
							OP_QUERY: begin
								push_res.is_active = running_q[c];
							end
							default: ;
						endcase
					end
				end
			end
			ST_TICK_EV: begin
				// an earlier expiry waits in pend until a later one or the end shows
				if (!(expire && pend_v_q && !out_free)) begin
					if (live) begin
						rem_we = !expire || periodic_rd;
						rem_wd = expire ? period_rd : rem_rd - 32'd1;
						if (expire && !periodic_rd) begin
							run_d[idx_q] = 1'b0;
						end
					end
					if (expire) begin
						if (pend_v_q) begin
							push = 1'b1;
							push_res = pend_q;
						end
						pend_v_d = 1'b1;
						pend_d = '0;
						pend_d.kind = KIND_EVENT;
						pend_d.channel = to_chan(idx_q);
						pend_d.tag_out = tag_rd;
					end
					if (idx_q == LAST_IDX) begin
						state_d = ST_TICK_END;
					end else begin
						idx_d = idx_q + 1'b1;
						raddr = idx_d;
					end
				end
			end
			ST_TICK_END: begin
				if (!pend_v_q) begin
					state_d = ST_IDLE;
				end else if (out_free) begin
					push = 1'b1;
					push_res = pend_q;
					push_res.last_item = 1'b1;
					pend_v_d = 1'b0;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q <= '0;
			pend_v_q <= 1'b0;
			allocated_q <= '0;
			running_q <= '0;
			out_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			idx_q <= idx_d;
			pend_v_q <= pend_v_d;
			allocated_q <= alloc_d;
			running_q <= run_d;
			if (push) begin
				out_v_q <= 1'b1;
			end else if (rsp.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		cur_q <= cur_d;
		pend_q <= pend_d;
		if (push) begin
			out_q <= push_res;
		end
	end

	// result word register
	assign rsp.valid = out_v_q;
	assign rsp.kind = out_q.kind;
	assign rsp.status = out_q.status;
	assign rsp.channel = out_q.channel;
	assign rsp.tag_out = out_q.tag_out;
	assign rsp.is_active = out_q.is_active;
	assign rsp.callback = out_q.callback;
	assign rsp.last_item = out_q.last_item;

	`MTS_ASSERT_IMP(a_run_alloc, clk, arst_n, 1'b1, (running_q & ~allocated_q) == '0,
		"running channel is not allocated")
	`MTS_ASSERT_IMP(a_pend_scan, clk, arst_n, state_q == ST_IDLE || state_q == ST_EXEC,
		!pend_v_q, "pending expiry outside a tick scan")
	`MTS_ASSERT_IMP(a_mid_event, clk, arst_n, out_v_q && !out_q.last_item,
		out_q.kind == KIND_EVENT, "non-final word is not an expiry event")
	`MTS_ASSERT_NXT(a_end_idle, clk, arst_n, state_q == ST_TICK_END && !pend_v_q,
		state_q == ST_IDLE, "tick scan did not finish")

endmodule

// File: rtl/multi_timer_service.sv
// Timer service with a table of NUM_TIMERS channels, driven by command words (tick, create,
// stop, restart, delete, query) and answering with result words; unknown function codes are
// taken and dropped. Commands first enter a two-word queue, so the command port keeps taking
// words while results wait. A command leaves the queue, the channel memories are read, and
// it then acts and gives its single response through the result word register. A tick scans
// the channels one per cycle, unless the result side stalls, through the shared read port of
// the channel memories; expiry events come out in ascending channel order and the last one
// carries last_item. A tick with no expiry gives no word. Intervals above 2147483646 are
// rejected at create; 0 expires on the next tick.
module multi_timer_service (
	input logic clk,
	input logic arst_n,
	mts_cmd_if.sink cmd,
	mts_rsp_if.source rsp
);
	import mts_pkg::*;

	logic q_valid;
	logic q_ready;
	qitem_t q_item;

	// command intake and queue
	mts_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.q_valid(q_valid),
		.q_item(q_item),
		.q_ready(q_ready)
	);

	// channel table and result register
	mts_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_valid(q_valid),
		.q_item(q_item),
		.q_ready(q_ready),
		.rsp(rsp)
	);

endmodule
